// ===== rtl/fanpwm_pkg.sv =====
package fanpwm_pkg;

    localparam int TEMP_W       = 16;
    localparam int DUTY_W       = 8;
    localparam int HIST_DEPTH   = 6;
    localparam int HIST_IDX_W   = $clog2(HIST_DEPTH + 1);
    localparam int WEIGHT_W     = 16;
    localparam int CFG_IDX_W    = 2;
    localparam int CFG_DATA_W   = 16;

    localparam logic signed [TEMP_W-1:0] EMPTY_MARK = -16'sd256;

    // register indexes of the configuration port
    localparam logic [CFG_IDX_W-1:0] CFG_CPU_NOTICE   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CPU_HALT     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BOARD_NOTICE = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_BOARD_MAX    = 2'd3;

    localparam logic signed [TEMP_W-1:0] RST_CPU_NOTICE   = 16'sd10240;
    localparam logic signed [TEMP_W-1:0] RST_CPU_HALT     = 16'sd17920;
    localparam logic signed [TEMP_W-1:0] RST_BOARD_NOTICE = 16'sd10240;
    localparam logic signed [TEMP_W-1:0] RST_BOARD_MAX    = 16'sd15360;

    // Q0.16 tap weights, oldest history entry first; they sum to 1.0
    function automatic logic [WEIGHT_W-1:0] tap_weight(input logic [HIST_IDX_W-1:0] idx);
        logic [WEIGHT_W-1:0] w;
        unique case (idx)
            3'd0:    w = 16'd3277;
            3'd1:    w = 16'd4915;
            3'd2:    w = 16'd7373;
            3'd3:    w = 16'd11062;
            3'd4:    w = 16'd16594;
            3'd5:    w = 16'd22315;
            default: w = '0;
        endcase
        return w;
    endfunction

endpackage

// ===== rtl/fanpwm_in_if.sv =====
interface fanpwm_in_if;
    import fanpwm_pkg::*;

    logic                     valid;
    logic                     ready;
    logic signed [TEMP_W-1:0] cpu_temp;
    logic signed [TEMP_W-1:0] board_temp;

    modport source (output valid, output cpu_temp, output board_temp, input ready);
    modport sink   (input valid, input cpu_temp, input board_temp, output ready);
endinterface

// ===== rtl/fanpwm_out_if.sv =====
interface fanpwm_out_if;
    import fanpwm_pkg::*;

    logic              valid;
    logic              ready;
    logic [DUTY_W-1:0] fan_duty;

    modport source (output valid, output fan_duty, input ready);
    modport sink   (input valid, input fan_duty, output ready);
endinterface

// ===== rtl/fan_pwm_from_weighted_temperature.sv =====
// Fan PWM duty from a weighted CPU temperature and the board temperature.
//
// i_in carries one CPU and one board sample (signed Q8.8 degrees C) per
// transfer; o_out returns one fan_duty (0..255) per input transfer, in order.
// The i_cfg_* port writes the four ramp thresholds; the user writes them
// only while the block is idle, which the block itself does not enforce.
// One sample at a time: i_in.ready is high only while the sequencer is idle.
// A shared multiply-accumulate forms the six-tap sum, then one shared
// restoring divider serves the CPU term and the board term in turn (load,
// saturation check, then 8 quotient bits at one quotient bit per cycle; a
// zero or saturated term stops after the load or the saturation check).
//
// o_out is a register: a finished duty waits there while the next sample is
// already taken and worked on. If the receiver still stalls when the next
// duty is done, hold it in the sequencer until the output register frees.
// Reset (synchronous, i_rst_n low) fills the history with the empty marker,
// loads the default thresholds and drops any pending result.
module fan_pwm_from_weighted_temperature (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    fanpwm_in_if.sink                           i_in,
    fanpwm_out_if.source                        o_out,
    input  logic                                i_cfg_we,
    input  logic [fanpwm_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [fanpwm_pkg::CFG_DATA_W-1:0]   i_cfg_data
);
    import fanpwm_pkg::*;

    // sequencer states
    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_MAC  = 3'd1;
    localparam logic [2:0] S_CAP  = 3'd2;
    localparam logic [2:0] S_LOAD = 3'd3;
    localparam logic [2:0] S_SAT  = 3'd4;
    localparam logic [2:0] S_DIV  = 3'd5;
    localparam logic [2:0] S_FIN  = 3'd6;

    // threshold registers
    logic signed [TEMP_W-1:0] r_cpu_notice, r_cpu_halt, r_board_notice, r_board_max;

    // CPU history, oldest first; the last entry holds the current sample
    logic signed [TEMP_W-1:0] r_hist [HIST_DEPTH];
    logic signed [TEMP_W-1:0] n_hist [HIST_DEPTH];

    logic [2:0]               r_state, n_state;
    logic signed [TEMP_W-1:0] r_cur, n_cur;
    logic signed [TEMP_W-1:0] r_board, n_board;
    logic [HIST_IDX_W-1:0]    r_idx, n_idx;
    logic signed [31:0]       r_prod, n_prod;
    logic signed [32:0]       r_acc, n_acc;
    logic                     r_term, n_term;     // 0: CPU term, 1: board term
    logic signed [33:0]       r_num, n_num;
    logic signed [32:0]       r_den, n_den;
    logic [39:0]              r_rem, n_rem;
    logic [31:0]              r_dvs, n_dvs;
    logic [39:0]              r_dsh, n_dsh;
    logic [2:0]               r_bit, n_bit;
    logic [DUTY_W-1:0]        r_quo, n_quo;
    logic [DUTY_W-1:0]        r_qc, n_qc;
    logic [DUTY_W-1:0]        r_qb, n_qb;
    logic                     r_out_valid, n_out_valid;
    logic [DUTY_W-1:0]        r_duty, n_duty;

    logic                     w_accept;
    logic signed [TEMP_W-1:0] w_tap;
    logic signed [31:0]       w_tap_ext, w_wt_ext;
    logic signed [32:0]       w_cap, w_capped;
    logic signed [16:0]       w_span_c, w_num_b, w_span_b;
    logic [39:0]              w_n255;
    logic [40:0]              w_trial;
    logic                     w_done;
    logic [DUTY_W-1:0]        w_q;

    assign w_accept     = i_in.valid && i_in.ready;
    assign i_in.ready   = (r_state == S_IDLE);
    assign o_out.valid    = r_out_valid;
    assign o_out.fan_duty = r_duty;

    // one tap per cycle through the shared multiplier
    assign w_tap     = (r_idx < HIST_IDX_W'(HIST_DEPTH)) ? r_hist[r_idx] : '0;
    assign w_tap_ext = {{(32 - TEMP_W){w_tap[TEMP_W-1]}}, w_tap};
    assign w_wt_ext  = {{(32 - WEIGHT_W){1'b0}}, tap_weight(r_idx)};

    // weighted value never above the current sample
    assign w_cap    = {r_cur[TEMP_W-1], r_cur, 16'h0000};
    assign w_capped = (r_acc > w_cap) ? w_cap : r_acc;
    assign w_span_c = {r_cpu_halt[TEMP_W-1], r_cpu_halt}
                    - {r_cpu_notice[TEMP_W-1], r_cpu_notice};
    assign w_num_b  = {r_board[TEMP_W-1], r_board}
                    - {r_board_notice[TEMP_W-1], r_board_notice};
    assign w_span_b = {r_board_max[TEMP_W-1], r_board_max}
                    - {r_board_notice[TEMP_W-1], r_board_notice};

    // numerator times 255 as a shift and subtract; numerator is below 2^32
    assign w_n255  = {r_num[31:0], 8'h00} - {8'h00, r_num[31:0]};
    assign w_trial = {1'b0, r_rem} - {1'b0, r_dsh};

    always_comb begin
        n_state     = r_state;
        n_hist      = r_hist;
        n_cur       = r_cur;
        n_board     = r_board;
        n_idx       = r_idx;
        n_prod      = r_prod;
        n_acc       = r_acc;
        n_term      = r_term;
        n_num       = r_num;
        n_den       = r_den;
        n_rem       = r_rem;
        n_dvs       = r_dvs;
        n_dsh       = r_dsh;
        n_bit       = r_bit;
        n_quo       = r_quo;
        n_qc        = r_qc;
        n_qb        = r_qb;
        n_duty      = r_duty;
        n_out_valid = r_out_valid;
        w_done      = 1'b0;
        w_q         = '0;

        // drop the result once the receiver takes it
        if (r_out_valid && o_out.ready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_cur   = i_in.cpu_temp;
                    n_board = i_in.board_temp;
                    // negative oldest entry: refill the whole history
                    if (r_hist[0][TEMP_W-1]) begin
                        for (int i = 0; i < HIST_DEPTH; i++) begin
                            n_hist[i] = i_in.cpu_temp;
                        end
                    end else begin
                        for (int i = 0; i < HIST_DEPTH - 1; i++) begin
                            n_hist[i] = r_hist[i+1];
                        end
                        n_hist[HIST_DEPTH-1] = i_in.cpu_temp;
                    end
                    n_acc   = '0;
                    n_idx   = '0;
                    n_state = S_MAC;
                end
            end
            S_MAC: begin
                // product registered in r_prod, accumulated in the next cycle
                if (r_idx != '0) begin
                    n_acc = r_acc + {r_prod[31], r_prod};
                end
                if (r_idx == HIST_IDX_W'(HIST_DEPTH)) begin
                    n_state = S_CAP;
                end else begin
                    n_prod = w_tap_ext * w_wt_ext;
                    n_idx  = r_idx + 1'b1;
                end
            end
            S_CAP: begin
                n_num   = {w_capped[32], w_capped}
                        - {{2{r_cpu_notice[TEMP_W-1]}}, r_cpu_notice, 16'h0000};
                n_den   = {w_span_c, 16'h0000};
                n_term  = 1'b0;
                n_state = S_LOAD;
            end
            S_LOAD: begin
                // non-positive span or numerator: term is zero after clamping
                if (r_den[32] || (r_den == '0) || r_num[33] || (r_num == '0)) begin
                    w_done = 1'b1;
                    w_q    = '0;
                end else begin
                    n_rem   = w_n255;
                    n_dvs   = r_den[31:0];
                    n_state = S_SAT;
                end
            end
            S_SAT: begin
                if (r_rem >= {r_dvs, 8'h00}) begin
                    w_done = 1'b1;
                    w_q    = '1;
                end else begin
                    n_dsh   = {1'b0, r_dvs, 7'h00};
                    n_bit   = 3'd7;
                    n_quo   = '0;
                    n_state = S_DIV;
                end
            end
            S_DIV: begin
                // one restoring step per cycle, quotient bit MSB first
                if (!w_trial[40]) begin
                    n_rem = w_trial[39:0];
                end
                n_quo = {r_quo[DUTY_W-2:0], ~w_trial[40]};
                n_dsh = r_dsh >> 1;
                n_bit = r_bit - 1'b1;
                if (r_bit == '0) begin
                    w_done = 1'b1;
                    w_q    = n_quo;
                end
            end
            S_FIN: begin
                if (!r_out_valid || o_out.ready) begin
                    n_duty      = (r_qc > r_qb) ? r_qc : r_qb;
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        // hand the divider to the board term, or finish
        if (w_done) begin
            if (!r_term) begin
                n_qc    = w_q;
                n_term  = 1'b1;
                n_num   = {{17{w_num_b[16]}}, w_num_b};
                n_den   = {{16{w_span_b[16]}}, w_span_b};
                n_state = S_LOAD;
            end else begin
                n_qb    = w_q;
                n_state = S_FIN;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= S_IDLE;
            r_out_valid    <= 1'b0;
            r_cpu_notice   <= RST_CPU_NOTICE;
            r_cpu_halt     <= RST_CPU_HALT;
            r_board_notice <= RST_BOARD_NOTICE;
            r_board_max    <= RST_BOARD_MAX;
            for (int i = 0; i < HIST_DEPTH; i++) begin
                r_hist[i] <= EMPTY_MARK;
            end
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            r_hist      <= n_hist;
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    CFG_CPU_NOTICE:   r_cpu_notice   <= i_cfg_data;
                    CFG_CPU_HALT:     r_cpu_halt     <= i_cfg_data;
                    CFG_BOARD_NOTICE: r_board_notice <= i_cfg_data;
                    CFG_BOARD_MAX:    r_board_max    <= i_cfg_data;
                    default: ;
                endcase
            end
        end
    end

    // datapath registers, no reset
    always_ff @(posedge i_clk) begin
        r_cur   <= n_cur;
        r_board <= n_board;
        r_idx   <= n_idx;
        r_prod  <= n_prod;
        r_acc   <= n_acc;
        r_term  <= n_term;
        r_num   <= n_num;
        r_den   <= n_den;
        r_rem   <= n_rem;
        r_dvs   <= n_dvs;
        r_dsh   <= n_dsh;
        r_bit   <= n_bit;
        r_quo   <= n_quo;
        r_qc    <= n_qc;
        r_qb    <= n_qb;
        r_duty  <= n_duty;
    end

endmodule
